[src/aczc_pkg.sv]
`timescale 1ns / 1ps

package aczc_pkg;

    localparam int TIME_W     = 32;
    localparam int FREQ_W     = 10;
    localparam int MARGIN_W   = 6;
    localparam int OFFSET_W   = 18;
    localparam int HALF_W     = 19;
    localparam int PHASE_W    = 7;
    localparam int DENOM_W    = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int DIV_W      = 32;
    localparam int CNT_W      = $clog2(DIV_W);

    localparam int PHASE_RESOLUTION = 100;
    localparam int PHASE_ALL_ONES   = (1 << PHASE_W) - 1;
    localparam int PHASE_LIMIT_INT  = (PHASE_RESOLUTION > PHASE_ALL_ONES) ?
                                      PHASE_ALL_ONES : PHASE_RESOLUTION;
    localparam logic [PHASE_W-1:0] PHASE_LIMIT = PHASE_W'(PHASE_LIMIT_INT);
    localparam logic [DIV_W-1:0]   PHASE_RES_W = DIV_W'(PHASE_RESOLUTION);

    localparam logic [DIV_W-1:0] HALF_SECOND_US = DIV_W'(500000);
    localparam logic [DIV_W-1:0] MIN_HALF_NUM   = DIV_W'(50000000);

    localparam logic [DENOM_W-1:0] PERCENT_FULL = DENOM_W'(100);

    localparam logic [FREQ_W-1:0]   MIN_FREQ_RESET = FREQ_W'(50);
    localparam logic [FREQ_W-1:0]   MAX_FREQ_RESET = FREQ_W'(60);
    localparam logic [MARGIN_W-1:0] MARGIN_RESET   = MARGIN_W'(10);
    localparam logic [FREQ_W-1:0]   FREQ_A_RESET   = FREQ_W'(50);
    localparam logic [FREQ_W-1:0]   FREQ_B_RESET   = FREQ_W'(60);
    localparam logic [HALF_W-1:0]   HALF_RESET     = HALF_W'(8333);

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_FREQ = 3'd0,
        CFG_MAX_FREQ = 3'd1,
        CFG_MARGIN   = 3'd2,
        CFG_FREQ_A   = 3'd3,
        CFG_FREQ_B   = 3'd4,
        CFG_OFFSET   = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_WAIT,
        ST_ACT_WAIT,
        ST_SNAP_PICK,
        ST_SNAP_CLAMP,
        ST_HP_WAIT,
        ST_TICK_WAIT,
        ST_PH_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_rsp;

    function automatic logic [DIV_W-1:0] nz(input logic [DIV_W-1:0] v);
        return (v == '0) ? DIV_W'(1) : v;
    endfunction

    function automatic logic [HALF_W-1:0] absdiff(input logic [HALF_W-1:0] a,
                                                  input logic [HALF_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

[src/aczc_div.sv]
`timescale 1ns / 1ps

module aczc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aczc_pkg::t_div_req i_req,
    output aczc_pkg::t_div_rsp o_rsp
);
    import aczc_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvs;

    logic [DIV_W:0] w_trial;
    logic           w_fits;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= DIV_W'(w_trial - {1'b0, r_dvs});
            end else begin
                r_rem <= w_trial[DIV_W-1:0];
            end
            r_quo <= {r_quo[DIV_W-2:0], w_fits};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

[src/ac_zero_cross_phase_tracker_top.sv]
`timescale 1ns / 1ps

// Mains zero-crossing phase tracker.
// The input channel (i_in_valid, o_in_stall) carries items of i_cmd and i_now_us:
// a zero-crossing edge (i_cmd low) or a timer tick (i_cmd high). The output
// channel (o_out_valid, i_out_stall) carries o_phase, the position inside the
// current half cycle scaled to the phase resolution.
// One item is worked on at a time; o_in_stall is high while an item is busy.
// All divisions run on one shared restoring divider that retires one quotient
// bit per cycle. A rejected edge uses one division; an accepted edge uses three
// divisions and passes the snap pick and snap clamp states before the third.
// A phase tick uses two divisions and then loads the output register; a tick
// whose time since the reference is not positive starts no division, and one
// with a zero remainder ends after the first.
// Edges never produce an item. Configuration writes on i_cfg_wr_en take
// effect at once and must only be made while the block is idle.
// Synchronous active-low reset restores the register defaults, a half period
// of 8333 us and unmasked edges, and empties the output register.
// A finished phase waits in the output register while i_out_stall is high;
// a following result then waits inside the block until the register is free.

module ac_zero_cross_phase_tracker_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic [aczc_pkg::TIME_W-1:0]       i_now_us,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [aczc_pkg::PHASE_W-1:0]      o_phase,
    input  logic                              i_cfg_wr_en,
    input  logic [aczc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aczc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import aczc_pkg::*;

    t_state r_state, n_state;

    logic [FREQ_W-1:0]   r_min_f;
    logic [FREQ_W-1:0]   r_max_f;
    logic [MARGIN_W-1:0] r_margin;
    logic [FREQ_W-1:0]   r_fa;
    logic [FREQ_W-1:0]   r_fb;
    logic [OFFSET_W-1:0] r_offset;

    logic [TIME_W-1:0] r_last, n_last;
    logic [TIME_W-1:0] r_ref, n_ref;
    logic [HALF_W-1:0] r_half, n_half;
    logic              r_mask, n_mask;
    logic              r_out_valid, n_out_valid;

    logic [TIME_W-1:0]  r_now, n_now;
    logic [HALF_W-1:0]  r_actual, n_actual;
    logic [FREQ_W-1:0]  r_closest, n_closest;
    logic [PHASE_W-1:0] r_phase_res, n_phase_res;
    logic [PHASE_W-1:0] r_phase, n_phase;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic [DENOM_W-1:0] w_denom;
    logic [DENOM_W-1:0] w_low_bound;
    logic [DENOM_W-1:0] w_close_pct;
    logic [TIME_W-1:0]  w_elapsed;
    logic [TIME_W-1:0]  w_du;
    logic [HALF_W-1:0]  w_half_nz;
    logic [HALF_W-1:0]  w_rem;
    logic [HALF_W-1:0]  w_d_max;
    logic [HALF_W-1:0]  w_d_a;
    logic [HALF_W-1:0]  w_d_b;
    logic [HALF_W-1:0]  w_d_best;
    logic [FREQ_W-1:0]  w_pick;
    logic [FREQ_W-1:0]  w_snap_f;
    logic [DIV_W-1:0]   w_phase_q;

    aczc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_denom     = DENOM_W'(DENOM_W'(r_max_f) * (PERCENT_FULL + DENOM_W'(r_margin)));
    assign w_low_bound = DENOM_W'(DENOM_W'(r_min_f) * (PERCENT_FULL - DENOM_W'(r_margin)));
    assign w_close_pct = DENOM_W'(DENOM_W'(r_closest) * PERCENT_FULL);
    assign w_elapsed   = r_now - r_last;
    assign w_du        = i_now_us - r_ref;
    assign w_half_nz   = (r_half == '0) ? HALF_W'(1) : r_half;
    assign w_rem       = w_div_rsp.remainder[HALF_W-1:0];
    assign w_phase_q   = (w_div_rsp.quotient > PHASE_RES_W) ? PHASE_RES_W
                                                            : w_div_rsp.quotient;

    always_comb begin
        w_d_max  = absdiff(HALF_W'(r_max_f), r_actual);
        w_d_a    = absdiff(HALF_W'(r_fa), r_actual);
        w_d_b    = absdiff(HALF_W'(r_fb), r_actual);
        w_pick   = r_max_f;
        w_d_best = w_d_max;
        if (w_d_a < w_d_best) begin
            w_pick   = r_fa;
            w_d_best = w_d_a;
        end
        if (w_d_b < w_d_best) begin
            w_pick = r_fb;
        end
    end

    always_comb begin
        if (w_close_pct < w_low_bound) begin
            w_snap_f = r_min_f;
        end else if (w_close_pct > w_denom) begin
            w_snap_f = r_max_f;
        end else begin
            w_snap_f = r_closest;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_ref       = r_ref;
        n_half      = r_half;
        n_mask      = r_mask;
        n_now       = r_now;
        n_actual    = r_actual;
        n_closest   = r_closest;
        n_phase_res = r_phase_res;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && i_out_stall;
        w_div_req   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_now = i_now_us;
                    if (i_cmd == CMD_EDGE) begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = MIN_HALF_NUM;
                        w_div_req.divisor  = nz(DIV_W'(w_denom));
                        n_state            = ST_EDGE_WAIT;
                    end else if (!w_du[TIME_W-1] && (w_du != '0)) begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = DIV_W'(w_du);
                        w_div_req.divisor  = DIV_W'(w_half_nz);
                        n_state            = ST_TICK_WAIT;
                    end
                end
            end
            ST_EDGE_WAIT: begin
                if (w_div_rsp.done) begin
                    if (!r_mask && (DIV_W'(w_elapsed) >= w_div_rsp.quotient)) begin
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = HALF_SECOND_US;
                        w_div_req.divisor  = nz(DIV_W'(w_elapsed));
                        n_state            = ST_ACT_WAIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ACT_WAIT: begin
                if (w_div_rsp.done) begin
                    n_actual = w_div_rsp.quotient[HALF_W-1:0];
                    n_state  = ST_SNAP_PICK;
                end
            end
            ST_SNAP_PICK: begin
                n_closest = w_pick;
                n_state   = ST_SNAP_CLAMP;
            end
            ST_SNAP_CLAMP: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = HALF_SECOND_US;
                w_div_req.divisor  = nz(DIV_W'(w_snap_f));
                n_state            = ST_HP_WAIT;
            end
            ST_HP_WAIT: begin
                if (w_div_rsp.done) begin
                    n_half  = w_div_rsp.quotient[HALF_W-1:0];
                    n_mask  = 1'b1;
                    n_last  = r_now;
                    n_ref   = r_now + TIME_W'(signed'(r_offset));
                    n_state = ST_IDLE;
                end
            end
            ST_TICK_WAIT: begin
                if (w_div_rsp.done) begin
                    if (w_rem == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        if (w_rem > (w_half_nz >> 1)) begin
                            n_mask = 1'b0;
                        end
                        w_div_req.start    = 1'b1;
                        w_div_req.dividend = DIV_W'(DIV_W'(w_rem) * PHASE_RES_W);
                        w_div_req.divisor  = DIV_W'(w_half_nz);
                        n_state            = ST_PH_WAIT;
                    end
                end
            end
            ST_PH_WAIT: begin
                if (w_div_rsp.done) begin
                    n_phase_res = w_phase_q[PHASE_W-1:0];
                    n_state     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_phase     = r_phase_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_ref       <= '0;
            r_half      <= HALF_RESET;
            r_mask      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_last      <= n_last;
            r_ref       <= n_ref;
            r_half      <= n_half;
            r_mask      <= n_mask;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_actual    <= n_actual;
        r_closest   <= n_closest;
        r_phase_res <= n_phase_res;
        r_phase     <= n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_f  <= MIN_FREQ_RESET;
            r_max_f  <= MAX_FREQ_RESET;
            r_margin <= MARGIN_RESET;
            r_fa     <= FREQ_A_RESET;
            r_fb     <= FREQ_B_RESET;
            r_offset <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_FREQ: r_min_f  <= i_cfg_wdata[FREQ_W-1:0];
                CFG_MAX_FREQ: r_max_f  <= i_cfg_wdata[FREQ_W-1:0];
                CFG_MARGIN:   r_margin <= i_cfg_wdata[MARGIN_W-1:0];
                CFG_FREQ_A:   r_fa     <= i_cfg_wdata[FREQ_W-1:0];
                CFG_FREQ_B:   r_fb     <= i_cfg_wdata[FREQ_W-1:0];
                CFG_OFFSET:   r_offset <= i_cfg_wdata[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_phase     = r_phase;

endmodule

[src/aczc_chk.sv]
`timescale 1ns / 1ps

module aczc_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              i_cmd,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [aczc_pkg::PHASE_W-1:0]      o_phase
);
    import aczc_pkg::*;

    logic w_in_take;

    assign w_in_take = i_in_valid && !o_in_stall;

    a_phase_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_phase <= PHASE_LIMIT)
    ) else $error("phase above resolution");

    a_busy_after_edge: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_in_take && (i_cmd == CMD_EDGE)) |=> o_in_stall
    ) else $error("edge item did not occupy the block");

    a_result_from_work: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall)
    ) else $error("result appeared without an item in progress");

    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_phase))
    ) else $error("stalled result changed");

endmodule

bind ac_zero_cross_phase_tracker_top aczc_chk u_aczc_chk (.*);

[bench/ac_zero_cross_phase_tracker_top_tb.sv]
`timescale 1ns / 1ps

module ac_zero_cross_phase_tracker_top_tb;
    import aczc_pkg::*;

    localparam int WANT_MODEL    = -2;
    localparam int WANT_NONE     = -1;
    localparam int PROBE_COUNT   = 22;
    localparam int FIXED_COUNT   = 7;
    localparam int PHASE_COUNT   = 20;
    localparam int PHASE_ITEMS   = 95;
    localparam int SETTLE_CYCLES = 160;
    localparam int DRAIN_CYCLES  = 200;
    localparam int QUIET_LIMIT   = 3000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] stamp;
        int                want;
    } t_probe_row;

    typedef struct packed {
        logic [FREQ_W-1:0]   min_hz;
        logic [FREQ_W-1:0]   max_hz;
        logic [MARGIN_W-1:0] margin_pct;
        logic [FREQ_W-1:0]   snap_a_hz;
        logic [FREQ_W-1:0]   snap_b_hz;
        logic [OFFSET_W-1:0] offset_us;
    } t_tracker_setup;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic                  i_cmd       = CMD_EDGE;
    logic [TIME_W-1:0]     i_now_us    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [PHASE_W-1:0]    o_phase;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    ac_zero_cross_phase_tracker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_now_us    (i_now_us),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_phase     (o_phase),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Tracker state and settings as the block should hold them.
    logic [FREQ_W-1:0]   set_min_hz    = MIN_FREQ_RESET;
    logic [FREQ_W-1:0]   set_max_hz    = MAX_FREQ_RESET;
    logic [MARGIN_W-1:0] set_margin    = MARGIN_RESET;
    logic [FREQ_W-1:0]   set_snap_a_hz = FREQ_A_RESET;
    logic [FREQ_W-1:0]   set_snap_b_hz = FREQ_B_RESET;
    logic [OFFSET_W-1:0] set_offset    = '0;
    logic [TIME_W-1:0]   edge_time     = '0;
    logic [TIME_W-1:0]   ref_time      = '0;
    logic [HALF_W-1:0]   half_us       = HALF_RESET;
    logic                edge_masked   = 1'b0;

    logic [PHASE_W-1:0] phase_expected_q [$];
    logic [PHASE_W-1:0] want_phase;
    int                 mismatch_count = 0;
    int                 quiet_cycles   = 0;
    int                 stall_run      = 0;
    int                 stall_pick;
    logic               calm           = 1'b0;

    t_probe_row probe_rows [PROBE_COUNT] = '{
        '{CMD_TICK, 32'd0,          WANT_NONE},
        '{CMD_TICK, 32'd1,          0},
        '{CMD_TICK, 32'd8332,       99},
        '{CMD_TICK, 32'd8333,       WANT_NONE},
        '{CMD_TICK, 32'hFFFF_FFFF,  WANT_NONE},
        '{CMD_TICK, 32'h7FFF_FFFF,  WANT_MODEL},
        '{CMD_TICK, 32'h8000_0000,  WANT_NONE},
        '{CMD_EDGE, 32'd0,          WANT_MODEL},
        '{CMD_EDGE, 32'd7574,       WANT_MODEL},
        '{CMD_EDGE, 32'd7575,       WANT_MODEL},
        '{CMD_EDGE, 32'd20000,      WANT_MODEL},
        '{CMD_TICK, 32'd11575,      48},
        '{CMD_EDGE, 32'd30000,      WANT_MODEL},
        '{CMD_TICK, 32'd12575,      60},
        '{CMD_EDGE, 32'd17575,      WANT_MODEL},
        '{CMD_TICK, 32'd27574,      99},
        '{CMD_TICK, 32'd52575,      50},
        '{CMD_EDGE, 32'd517576,     WANT_MODEL},
        '{CMD_TICK, 32'd517579,     WANT_MODEL},
        '{CMD_EDGE, 32'hFFFF_FFF0,  WANT_MODEL},
        '{CMD_TICK, 32'h0000_1000,  WANT_MODEL},
        '{CMD_EDGE, 32'hFFFF_FFFF,  WANT_MODEL}
    };

    t_tracker_setup fixed_setups [FIXED_COUNT] = '{
        '{10'd50,   10'd60,   6'd10, 10'd50,   10'd60,   18'd0},
        '{10'd0,    10'd0,    6'd0,  10'd0,    10'd0,    18'd0},
        '{10'd1023, 10'd1023, 6'd63, 10'd1023, 10'd1023, 18'h1FFFF},
        '{10'd50,   10'd60,   6'd10, 10'd50,   10'd60,   18'h20000},
        '{10'd1000, 10'd60,   6'd10, 10'd50,   10'd60,   OFFSET_W'(-5000)},
        '{10'd50,   10'd100,  6'd10, 10'd115,  10'd50,   18'd0},
        '{10'd45,   10'd65,   6'd50, 10'd50,   10'd60,   18'd1234}
    };

    function automatic longint half_of_freq(input logic [FREQ_W-1:0] f);
        longint fl;
        fl = longint'(f);
        if (fl == 0) fl = 1;
        return (500000 / fl) & 'h7FFFF;
    endfunction

    function automatic longint shortest_half();
        longint hi, mg, denom;
        hi = longint'(set_max_hz);
        mg = longint'(set_margin);
        denom = hi * (100 + mg);
        if (denom == 0) denom = 1;
        return 50000000 / denom;
    endfunction

    function automatic longint freq_gap(input longint a, input longint b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic longint snapped_half(input logic [TIME_W-1:0] elapsed);
        longint el, actual, pick, lo, hi, mg, fa, fb;
        el = longint'(elapsed);
        if (el == 0) el = 1;
        actual = 500000 / el;
        lo = longint'(set_min_hz);
        hi = longint'(set_max_hz);
        mg = longint'(set_margin);
        fa = longint'(set_snap_a_hz);
        fb = longint'(set_snap_b_hz);
        pick = hi;
        if (freq_gap(fa, actual) < freq_gap(pick, actual)) pick = fa;
        if (freq_gap(fb, actual) < freq_gap(pick, actual)) pick = fb;
        if (pick * 100 < lo * (100 - mg)) return half_of_freq(set_min_hz);
        if (pick * 100 > hi * (100 + mg)) return half_of_freq(set_max_hz);
        return half_of_freq(pick[FREQ_W-1:0]);
    endfunction

    function automatic void advance_tracker(input logic kind, input logic [TIME_W-1:0] stamp,
                                            output logic emits,
                                            output logic [PHASE_W-1:0] phase);
        logic [TIME_W-1:0] elapsed, since_ref;
        longint span, rem, hp, ph;
        emits = 1'b0;
        phase = '0;
        if (kind == CMD_EDGE) begin
            elapsed = stamp - edge_time;
            span = longint'(elapsed);
            if (!edge_masked && span >= shortest_half()) begin
                edge_masked = 1'b1;
                edge_time = stamp;
                ref_time = stamp + {{(TIME_W-OFFSET_W){set_offset[OFFSET_W-1]}}, set_offset};
                half_us = HALF_W'(snapped_half(elapsed));
            end
        end else begin
            hp = longint'(half_us);
            if (hp == 0) hp = 1;
            since_ref = stamp - ref_time;
            span = longint'($signed(since_ref));
            rem = span % hp;
            if (rem > 0) begin
                if (rem > hp / 2) edge_masked = 1'b0;
                ph = PHASE_RESOLUTION * rem / hp;
                if (ph > PHASE_RESOLUTION) ph = PHASE_RESOLUTION;
                emits = 1'b1;
                phase = ph[PHASE_W-1:0];
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [FREQ_W-1:0] random_hz();
        if ($urandom_range(0, 6) == 0) return FREQ_W'($urandom_range(0, 1023));
        return FREQ_W'($urandom_range(1, 1000));
    endfunction

    function automatic t_tracker_setup random_setup();
        t_tracker_setup s;
        s.min_hz = random_hz();
        s.max_hz = random_hz();
        s.margin_pct = ($urandom_range(0, 9) == 0) ? MARGIN_W'($urandom_range(51, 63))
                                                   : MARGIN_W'($urandom_range(0, 50));
        s.snap_a_hz = random_hz();
        s.snap_b_hz = random_hz();
        s.offset_us = OFFSET_W'($urandom);
        return s;
    endfunction

    function automatic int pick_line_half();
        case ($urandom_range(0, 4))
            0: return int'(half_of_freq(set_snap_a_hz));
            1: return int'(half_of_freq(set_snap_b_hz));
            2: return int'(half_of_freq(set_max_hz));
            3: return int'(shortest_half()) + $urandom_range(0, 20);
            default: return $urandom_range(400, 20000);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic send_item(input logic kind, input logic [TIME_W-1:0] stamp, input int want);
        int gap;
        logic emits;
        logic [PHASE_W-1:0] phase;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= kind;
        i_now_us <= stamp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_tracker(kind, stamp, emits, phase);
        if (want == WANT_MODEL) begin
            if (emits) phase_expected_q.push_back(phase);
        end else if (want != WANT_NONE) begin
            phase_expected_q.push_back(want[PHASE_W-1:0]);
        end
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_FREQ: set_min_hz = data[FREQ_W-1:0];
            CFG_MAX_FREQ: set_max_hz = data[FREQ_W-1:0];
            CFG_MARGIN:   set_margin = data[MARGIN_W-1:0];
            CFG_FREQ_A:   set_snap_a_hz = data[FREQ_W-1:0];
            CFG_FREQ_B:   set_snap_b_hz = data[FREQ_W-1:0];
            CFG_OFFSET:   set_offset = data[OFFSET_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(input t_tracker_setup s);
        while (phase_expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_register(CFG_MIN_FREQ, CFG_DATA_W'(s.min_hz));
        write_register(CFG_MAX_FREQ, CFG_DATA_W'(s.max_hz));
        write_register(CFG_MARGIN, CFG_DATA_W'(s.margin_pct));
        write_register(CFG_FREQ_A, CFG_DATA_W'(s.snap_a_hz));
        write_register(CFG_FREQ_B, CFG_DATA_W'(s.snap_b_hz));
        write_register(CFG_OFFSET, CFG_DATA_W'(s.offset_us));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly a plausible mains waveform: an edge each half period with a few
    // ticks around it, mixed with random items and edges that come too early.
    task automatic run_mains_phase(input int count);
        logic [TIME_W-1:0] line_time;
        int line_half, jit, ticks, done_n, r;
        line_time = $urandom;
        line_half = pick_line_half();
        done_n = 0;
        while (done_n < count) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_item(1'($urandom_range(0, 1)), $urandom, WANT_MODEL);
                done_n++;
            end else if (r < 16) begin
                send_item(CMD_EDGE, line_time + $urandom_range(1, line_half / 2 + 1), WANT_MODEL);
                done_n++;
            end else begin
                send_item(CMD_EDGE, line_time, WANT_MODEL);
                ticks = $urandom_range(1, 5);
                repeat (ticks) begin
                    send_item(CMD_TICK, line_time + $urandom_range(0, line_half + line_half / 4),
                              WANT_MODEL);
                end
                done_n += ticks + 1;
                jit = int'($urandom_range(0, line_half / 25)) - line_half / 50;
                line_time = line_time + 32'(line_half) + 32'(jit);
                if ($urandom_range(0, 9) == 0) line_half = pick_line_half();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (phase_expected_q.size() == 0) begin
                report_mismatch($sformatf("phase %0d arrived with nothing expected", o_phase));
            end else begin
                want_phase = phase_expected_q.pop_front();
                if (o_phase !== want_phase) begin
                    report_mismatch($sformatf("phase expected %0d, got %0d",
                                              want_phase, o_phase));
                end
            end
        end
        if (calm) begin
            i_out_stall <= 1'b0;
            stall_run = 0;
        end else if (stall_run > 0) begin
            stall_run = stall_run - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 60) begin
                i_out_stall <= 1'b0;
                stall_run = $urandom_range(0, 7);
            end else if (stall_pick < 93) begin
                i_out_stall <= 1'b1;
                stall_run = $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_run = $urandom_range(14, 39);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int row, ph_idx;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (row = 0; row < PROBE_COUNT; row++) begin
            send_item(probe_rows[row].kind, probe_rows[row].stamp, probe_rows[row].want);
        end
        for (ph_idx = 0; ph_idx < PHASE_COUNT; ph_idx++) begin
            i_in_valid <= 1'b0;
            calm = (ph_idx % 5 == 3);
            apply_setup((ph_idx < FIXED_COUNT) ? fixed_setups[ph_idx] : random_setup());
            run_mains_phase(PHASE_ITEMS);
        end
        i_in_valid <= 1'b0;
        while (phase_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && phase_expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
